### design/gsa_pkg.sv
package gsa_pkg;

   localparam int MAX_LEN    = 32;
   localparam int LEN_W      = $clog2(MAX_LEN + 1);
   localparam int IDX_W      = $clog2(MAX_LEN);
   localparam int COL_W      = $clog2(2 * MAX_LEN + 1);
   localparam int PATH_W     = $clog2(2 * MAX_LEN);
   localparam int PATH_DEPTH = 2 * MAX_LEN;
   localparam int DIR_AW     = 2 * IDX_W;
   localparam int DIR_DEPTH  = 1 << DIR_AW;
   localparam int SYM_W      = 8;
   localparam int CFG_W      = 5;
   localparam int SCORE_W    = 11;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 2;

   typedef logic signed [SCORE_W-1:0] score_type;
   typedef logic signed [CFG_W-1:0]   cfg_type;
   typedef logic [SYM_W-1:0]          sym_type;

   localparam cfg_type GAP_RESET      = -5'sd2;
   localparam cfg_type MATCH_RESET    = 5'sd0;
   localparam cfg_type MISMATCH_RESET = -5'sd1;

   typedef enum logic [KIND_W-1:0] {
      KIND_APPEND_A = 2'd0,
      KIND_APPEND_B = 2'd1,
      KIND_ALIGN    = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAP      = 2'd0,
      CSR_MATCH    = 2'd1,
      CSR_MISMATCH = 2'd2
   } csr_type;

   typedef enum logic [1:0] {
      DIR_LEFT = 2'd1,
      DIR_DIAG = 2'd2,
      DIR_UP   = 2'd3
   } dir_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_ROW,
      ST_FILL_RD,
      ST_FILL_CALC,
      ST_TB_RD,
      ST_TB_STEP,
      ST_EM_RD,
      ST_EM_OUT,
      ST_EMPTY
   } state_type;

   typedef struct packed {
      score_type score;
      dir_type   dir;
   } cell_res_type;

endpackage

### design/gsa_cell.sv
module gsa_cell (
   input  gsa_pkg::score_type    diag,
   input  gsa_pkg::score_type    up,
   input  gsa_pkg::score_type    left,
   input  gsa_pkg::sym_type      sym_a,
   input  gsa_pkg::sym_type      sym_b,
   input  gsa_pkg::score_type    gap,
   input  gsa_pkg::score_type    match,
   input  gsa_pkg::score_type    mismatch,
   output gsa_pkg::cell_res_type res
);
   import gsa_pkg::*;

   score_type diag_s;
   score_type up_s;
   score_type left_s;

   assign diag_s = diag + ((sym_a == sym_b) ? match : mismatch);
   assign up_s   = up + gap;
   assign left_s = left + gap;

   // ties keep diagonal, then up
   always_comb begin
      res.score = diag_s;
      res.dir   = DIR_DIAG;
      if (up_s > res.score) begin
         res.score = up_s;
         res.dir   = DIR_UP;
      end
      if (left_s > res.score) begin
         res.score = left_s;
         res.dir   = DIR_LEFT;
      end
   end

endmodule

### design/global_sequence_aligner_core.sv
// Global (Needleman-Wunsch) aligner. Items with kind 0 or 1 append a byte to
// string A or B and are taken without raising busy; a byte past 32 symbols
// is dropped and reported as truncated on the next alignment. An align item
// holds busy while one shared cell unit fills the score matrix through the
// score-row memory, and then walks the direction memory back from the
// corner. Results come out one every other cycle, each on rsp_valid for one
// cycle only, and must be taken as they appear; the last is marked by
// rsp_last_column. Both strings and the truncation flag are cleared once the
// last result is out.
module global_sequence_aligner_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [gsa_pkg::KIND_W-1:0]      req_kind,
   input  gsa_pkg::sym_type                req_symbol,
   input  logic                            csr_write_enable,
   input  logic [gsa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gsa_pkg::CFG_W-1:0]       csr_wdata,
   output logic                            rsp_valid,
   output gsa_pkg::score_type              rsp_final_score,
   output gsa_pkg::sym_type                rsp_column_a,
   output gsa_pkg::sym_type                rsp_column_b,
   output logic                            rsp_gap_in_a,
   output logic                            rsp_gap_in_b,
   output logic                            rsp_no_column,
   output logic                            rsp_truncated,
   output logic                            rsp_last_column
);
   import gsa_pkg::*;

   state_type state_ff, state_in;
   logic [LEN_W-1:0] len_a_ff, len_a_in, len_b_ff, len_b_in;
   logic ovf_ff, ovf_in;
   cfg_type gap_ff, match_ff, mismatch_ff;

   logic [LEN_W-1:0] m_ff, m_in, n_ff, n_in;
   logic trunc_ff, trunc_in;
   logic [LEN_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [LEN_W-1:0] ti_ff, ti_in, tj_ff, tj_in;
   logic [LEN_W-1:0] ei_ff, ei_in, ej_ff, ej_in;
   logic [COL_W-1:0] cols_ff, cols_in, k_ff, k_in;
   score_type acc_ff, acc_in, row_base_ff, row_base_in;
   score_type diag_ff, diag_in, left_ff, left_in, final_ff, final_in;

   logic rsp_valid_ff, rsp_valid_in;
   score_type rsp_score_ff, rsp_score_in;
   sym_type rsp_a_ff, rsp_a_in, rsp_b_ff, rsp_b_in;
   logic rsp_ga_ff, rsp_ga_in, rsp_gb_ff, rsp_gb_in;
   logic rsp_none_ff, rsp_none_in, rsp_trunc_ff, rsp_trunc_in;
   logic rsp_last_ff, rsp_last_in;

   sym_type string_a_ff [MAX_LEN];
   sym_type string_b_ff [MAX_LEN];
   logic a_we, b_we;

   score_type score_mem [MAX_LEN];
   logic sc_we;
   logic [IDX_W-1:0] sc_addr;
   score_type sc_wdata, sc_rdata_ff;

   dir_type dir_mem [DIR_DEPTH];
   logic dir_we;
   logic [DIR_AW-1:0] dir_waddr, dir_raddr;
   dir_type dir_rdata_ff;

   dir_type path_mem [PATH_DEPTH];
   logic path_we;
   dir_type path_wdata, path_rdata_ff;
   logic [COL_W-1:0] path_ridx;

   logic [LEN_W-1:0] im1, jm1, tim1, tjm1, ti_next, tj_next;
   logic [IDX_W-1:0] a_idx, b_idx;
   sym_type sym_a, sym_b;
   score_type gap_ext, match_ext, mismatch_ext;
   cell_res_type cell_res;
   dir_type tb_dir;
   logic em_last;

   assign gap_ext      = score_type'(gap_ff);
   assign match_ext    = score_type'(match_ff);
   assign mismatch_ext = score_type'(mismatch_ff);

   assign im1  = i_ff - LEN_W'(1);
   assign jm1  = j_ff - LEN_W'(1);
   assign tim1 = ti_ff - LEN_W'(1);
   assign tjm1 = tj_ff - LEN_W'(1);

   assign a_idx = (state_ff == ST_EM_OUT) ? ei_ff[IDX_W-1:0] : im1[IDX_W-1:0];
   assign b_idx = (state_ff == ST_EM_OUT) ? ej_ff[IDX_W-1:0] : jm1[IDX_W-1:0];
   assign sym_a = string_a_ff[a_idx];
   assign sym_b = string_b_ff[b_idx];

   assign sc_addr   = jm1[IDX_W-1:0];
   assign dir_waddr = {im1[IDX_W-1:0], jm1[IDX_W-1:0]};
   assign dir_raddr = {tim1[IDX_W-1:0], tjm1[IDX_W-1:0]};
   assign path_ridx = cols_ff - COL_W'(1) - k_ff;
   assign em_last   = (k_ff == cols_ff - COL_W'(1));

   gsa_cell u_cell (
      .diag     (diag_ff),
      .up       (sc_rdata_ff),
      .left     (left_ff),
      .sym_a    (sym_a),
      .sym_b    (sym_b),
      .gap      (gap_ext),
      .match    (match_ext),
      .mismatch (mismatch_ext),
      .res      (cell_res)
   );

   always_comb begin
      if (ti_ff == '0) begin
         tb_dir = DIR_LEFT;
      end else if (tj_ff == '0) begin
         tb_dir = DIR_UP;
      end else begin
         tb_dir = dir_rdata_ff;
      end
      ti_next = ti_ff;
      tj_next = tj_ff;
      case (tb_dir)
         DIR_DIAG: begin
            ti_next = tim1;
            tj_next = tjm1;
         end
         DIR_LEFT: begin
            tj_next = tjm1;
         end
         default: begin
            ti_next = tim1;
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      len_a_in    = len_a_ff;
      len_b_in    = len_b_ff;
      ovf_in      = ovf_ff;
      m_in        = m_ff;
      n_in        = n_ff;
      trunc_in    = trunc_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      ti_in       = ti_ff;
      tj_in       = tj_ff;
      ei_in       = ei_ff;
      ej_in       = ej_ff;
      cols_in     = cols_ff;
      k_in        = k_ff;
      acc_in      = acc_ff;
      row_base_in = row_base_ff;
      diag_in     = diag_ff;
      left_in     = left_ff;
      final_in    = final_ff;
      a_we        = 1'b0;
      b_we        = 1'b0;
      sc_we       = 1'b0;
      sc_wdata    = acc_ff;
      dir_we      = 1'b0;
      path_we     = 1'b0;
      path_wdata  = tb_dir;

      rsp_valid_in = 1'b0;
      rsp_score_in = final_ff;
      rsp_a_in     = '0;
      rsp_b_in     = '0;
      rsp_ga_in    = 1'b0;
      rsp_gb_in    = 1'b0;
      rsp_none_in  = 1'b0;
      rsp_trunc_in = trunc_ff;
      rsp_last_in  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_kind)
                  KIND_APPEND_A: begin
                     if (len_a_ff < LEN_W'(MAX_LEN)) begin
                        a_we     = 1'b1;
                        len_a_in = len_a_ff + LEN_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  KIND_APPEND_B: begin
                     if (len_b_ff < LEN_W'(MAX_LEN)) begin
                        b_we     = 1'b1;
                        len_b_in = len_b_ff + LEN_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  KIND_ALIGN: begin
                     m_in        = len_a_ff;
                     n_in        = len_b_ff;
                     trunc_in    = ovf_ff;
                     i_in        = LEN_W'(1);
                     j_in        = LEN_W'(1);
                     acc_in      = gap_ext;
                     final_in    = '0;
                     row_base_in = '0;
                     state_in    = ST_INIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_INIT: begin
            if (j_ff > n_ff) begin
               if (m_ff == '0) begin
                  ti_in    = m_ff;
                  tj_in    = n_ff;
                  cols_in  = '0;
                  state_in = (n_ff == '0) ? ST_EMPTY : ST_TB_RD;
               end else begin
                  state_in = ST_ROW;
               end
            end else begin
               sc_we    = 1'b1;
               sc_wdata = acc_ff;
               final_in = acc_ff;
               acc_in   = acc_ff + gap_ext;
               j_in     = j_ff + LEN_W'(1);
            end
         end
         ST_ROW: begin
            diag_in     = row_base_ff;
            left_in     = row_base_ff + gap_ext;
            row_base_in = row_base_ff + gap_ext;
            final_in    = row_base_ff + gap_ext;
            j_in        = LEN_W'(1);
            if (n_ff == '0) begin
               if (i_ff == m_ff) begin
                  ti_in    = m_ff;
                  tj_in    = n_ff;
                  cols_in  = '0;
                  state_in = ST_TB_RD;
               end else begin
                  i_in = i_ff + LEN_W'(1);
               end
            end else begin
               state_in = ST_FILL_RD;
            end
         end
         ST_FILL_RD: begin
            state_in = ST_FILL_CALC;
         end
         ST_FILL_CALC: begin
            sc_we    = 1'b1;
            sc_wdata = cell_res.score;
            dir_we   = 1'b1;
            diag_in  = sc_rdata_ff;
            left_in  = cell_res.score;
            final_in = cell_res.score;
            if (j_ff == n_ff) begin
               if (i_ff == m_ff) begin
                  ti_in    = m_ff;
                  tj_in    = n_ff;
                  cols_in  = '0;
                  state_in = ST_TB_RD;
               end else begin
                  i_in     = i_ff + LEN_W'(1);
                  state_in = ST_ROW;
               end
            end else begin
               j_in     = j_ff + LEN_W'(1);
               state_in = ST_FILL_RD;
            end
         end
         ST_TB_RD: begin
            state_in = ST_TB_STEP;
         end
         ST_TB_STEP: begin
            path_we = 1'b1;
            cols_in = cols_ff + COL_W'(1);
            ti_in   = ti_next;
            tj_in   = tj_next;
            if (ti_next == '0 && tj_next == '0) begin
               k_in     = '0;
               ei_in    = '0;
               ej_in    = '0;
               state_in = ST_EM_RD;
            end else begin
               state_in = ST_TB_RD;
            end
         end
         ST_EM_RD: begin
            state_in = ST_EM_OUT;
         end
         ST_EM_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = em_last;
            case (path_rdata_ff)
               DIR_DIAG: begin
                  rsp_a_in = sym_a;
                  rsp_b_in = sym_b;
                  ei_in    = ei_ff + LEN_W'(1);
                  ej_in    = ej_ff + LEN_W'(1);
               end
               DIR_LEFT: begin
                  rsp_b_in  = sym_b;
                  rsp_ga_in = 1'b1;
                  ej_in     = ej_ff + LEN_W'(1);
               end
               default: begin
                  rsp_a_in  = sym_a;
                  rsp_gb_in = 1'b1;
                  ei_in     = ei_ff + LEN_W'(1);
               end
            endcase
            k_in = k_ff + COL_W'(1);
            if (em_last) begin
               len_a_in = '0;
               len_b_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_EM_RD;
            end
         end
         ST_EMPTY: begin
            rsp_valid_in = 1'b1;
            rsp_none_in  = 1'b1;
            rsp_last_in  = 1'b1;
            len_a_in     = '0;
            len_b_in     = '0;
            ovf_in       = 1'b0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_a_ff     <= '0;
         len_b_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gap_ff       <= GAP_RESET;
         match_ff     <= MATCH_RESET;
         mismatch_ff  <= MISMATCH_RESET;
      end else begin
         state_ff     <= state_in;
         len_a_ff     <= len_a_in;
         len_b_ff     <= len_b_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_GAP:      gap_ff      <= csr_wdata;
               CSR_MATCH:    match_ff    <= csr_wdata;
               CSR_MISMATCH: mismatch_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      m_ff         <= m_in;
      n_ff         <= n_in;
      trunc_ff     <= trunc_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      ti_ff        <= ti_in;
      tj_ff        <= tj_in;
      ei_ff        <= ei_in;
      ej_ff        <= ej_in;
      cols_ff      <= cols_in;
      k_ff         <= k_in;
      acc_ff       <= acc_in;
      row_base_ff  <= row_base_in;
      diag_ff      <= diag_in;
      left_ff      <= left_in;
      final_ff     <= final_in;
      rsp_score_ff <= rsp_score_in;
      rsp_a_ff     <= rsp_a_in;
      rsp_b_ff     <= rsp_b_in;
      rsp_ga_ff    <= rsp_ga_in;
      rsp_gb_ff    <= rsp_gb_in;
      rsp_none_ff  <= rsp_none_in;
      rsp_trunc_ff <= rsp_trunc_in;
      rsp_last_ff  <= rsp_last_in;
      if (a_we) begin
         string_a_ff[len_a_ff[IDX_W-1:0]] <= req_symbol;
      end
      if (b_we) begin
         string_b_ff[len_b_ff[IDX_W-1:0]] <= req_symbol;
      end
   end

   always_ff @(posedge clock) begin
      if (sc_we) begin
         score_mem[sc_addr] <= sc_wdata;
      end
      sc_rdata_ff <= score_mem[sc_addr];
   end

   always_ff @(posedge clock) begin
      if (dir_we) begin
         dir_mem[dir_waddr] <= cell_res.dir;
      end
      dir_rdata_ff <= dir_mem[dir_raddr];
   end

   always_ff @(posedge clock) begin
      if (path_we) begin
         path_mem[cols_ff[PATH_W-1:0]] <= path_wdata;
      end
      path_rdata_ff <= path_mem[path_ridx[PATH_W-1:0]];
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_final_score = rsp_score_ff;
   assign rsp_column_a    = rsp_a_ff;
   assign rsp_column_b    = rsp_b_ff;
   assign rsp_gap_in_a    = rsp_ga_ff;
   assign rsp_gap_in_b    = rsp_gb_ff;
   assign rsp_no_column   = rsp_none_ff;
   assign rsp_truncated   = rsp_trunc_ff;
   assign rsp_last_column = rsp_last_ff;

endmodule
